### sv/lru_key_value_cache_core_defines.svh
// Assertion macros shared by the cache core.
// Expects clk and rst in the scope of each use.
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// check cons in the same cycle as ante
`define LKVC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check cons in the cycle after ante
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/lkvc_pkg.sv
// Types and constants for the LRU key-value cache core.
// No dependencies.
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int RANK_W  = IDX_W;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } lkvc_req_t;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [DATA_W-1:0] evicted_key;
  } lkvc_rsp_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] victim_idx;
    logic [IDX_W-1:0] free_idx;
  } lkvc_match_t;

endpackage

### sv/lkvc_lookup.sv
// Associative key match, LRU victim pick and free slot search.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_lookup (
  input  logic [lkvc_pkg::ENTRIES-1:0]                     valid,
  input  logic [lkvc_pkg::ENTRIES-1:0][lkvc_pkg::DATA_W-1:0] keys,
  input  logic [lkvc_pkg::ENTRIES-1:0][lkvc_pkg::RANK_W-1:0] ranks,
  input  logic [lkvc_pkg::DATA_W-1:0]                      key,
  input  logic [lkvc_pkg::OCC_W-1:0]                       occupancy,
  input  logic                                             evict,
  output lkvc_pkg::lkvc_match_t                            match
);
  import lkvc_pkg::*;

  logic [OCC_W-1:0]   occ_m1;
  logic [RANK_W-1:0]  lru_rank;
  logic [ENTRIES-1:0] victim_hot;
  logic [ENTRIES-1:0] open;

  assign occ_m1   = occupancy - OCC_W'(1);
  assign lru_rank = occ_m1[RANK_W-1:0];

  always_comb begin
    match = '0;
    victim_hot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid[i] && keys[i] == key) begin
        match.hit     = 1'b1;
        match.hit_idx = IDX_W'(i);
      end
      if (valid[i] && ranks[i] == lru_rank) begin
        victim_hot[i]    = 1'b1;
        match.victim_idx = IDX_W'(i);
      end
    end
    open = ~valid | (victim_hot & {ENTRIES{evict}});
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (open[i]) begin
        match.free_idx = IDX_W'(i);
      end
    end
  end

endmodule

### sv/lru_key_value_cache_core.sv
// Fully associative key-value cache with LRU replacement.
// Throughput: one transaction per cycle; start is registered into the input stage, then done into the result stage.
// busy stays low, so start is taken every cycle; done cannot be stalled.
// rst (synchronous) clears all entries, occupancy and sets capacity to 16.
// Depends on lkvc_pkg, lkvc_lookup and lru_key_value_cache_core_defines.svh.
`timescale 1ns / 1ps

module lru_key_value_cache_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  lkvc_pkg::lkvc_req_t            req,
  output logic                           done,
  output lkvc_pkg::lkvc_rsp_t            rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]     cfg_data
);
  import lkvc_pkg::*;

  `include "lru_key_value_cache_core_defines.svh"

  logic [ENTRIES-1:0]                    entry_valid;
  logic [ENTRIES-1:0][DATA_W-1:0]        entry_key;
  logic [ENTRIES-1:0][DATA_W-1:0]        entry_value;
  logic [ENTRIES-1:0][RANK_W-1:0]        recency_rank;
  logic [OCC_W-1:0]                      occupancy;
  logic [CAP_W-1:0]                      capacity;

  logic                                  stage_valid;
  lkvc_req_t                             stage_req;

  logic [CMP_W-1:0]                      eff_cap;
  logic                                  set_miss;
  logic                                  evict;
  lkvc_match_t                           match;
  logic [RANK_W-1:0]                     hit_rank;
  logic [ENTRIES-1:0]                    kept;
  lkvc_rsp_t                             rsp_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    eff_cap = CMP_W'(capacity);
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end
  end

  assign set_miss = stage_req.operation == OP_SET && !match.hit;
  assign evict    = set_miss && CMP_W'(occupancy) >= eff_cap;

  lkvc_lookup u_lookup (
    .valid     (entry_valid),
    .keys      (entry_key),
    .ranks     (recency_rank),
    .key       (stage_req.key),
    .occupancy (occupancy),
    .evict     (evict),
    .match     (match)
  );

  assign hit_rank = recency_rank[match.hit_idx];

  always_comb begin
    kept = entry_valid;
    if (evict) begin
      kept[match.victim_idx] = 1'b0;
    end
  end

  always_comb begin
    rsp_next.found       = match.hit;
    rsp_next.evicted     = evict;
    rsp_next.evicted_key = evict ? entry_key[match.victim_idx] : '0;
    if (stage_req.operation == OP_GET) begin
      rsp_next.read_value = match.hit ? entry_value[match.hit_idx] : MISS_VALUE;
    end else begin
      rsp_next.read_value = '0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= start && !busy;
    end
    if (start && !busy) begin
      stage_req <= req;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid;
    end
    rsp <= rsp_next;
  end

  // capacity register: take writes only while empty
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready && occupancy == '0) begin
      capacity <= cfg_data;
    end
  end

  // entry state update
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      recency_rank <= '0;
      occupancy    <= '0;
    end else if (stage_valid) begin
      if (match.hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == match.hit_idx) begin
            recency_rank[i] <= '0;
          end else if (entry_valid[i] && recency_rank[i] < hit_rank) begin
            recency_rank[i] <= recency_rank[i] + RANK_W'(1);
          end
        end
      end else if (set_miss) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == match.free_idx) begin
            entry_valid[i]  <= 1'b1;
            recency_rank[i] <= '0;
          end else begin
            entry_valid[i] <= kept[i];
            if (kept[i]) begin
              recency_rank[i] <= recency_rank[i] + RANK_W'(1);
            end
          end
        end
        if (!evict) begin
          occupancy <= occupancy + OCC_W'(1);
        end
      end
    end
  end

  // entry payload update
  always_ff @(posedge clk) begin
    if (stage_valid && stage_req.operation == OP_SET) begin
      if (match.hit) begin
        entry_value[match.hit_idx] <= stage_req.value;
      end else begin
        entry_key[match.free_idx]   <= stage_req.key;
        entry_value[match.free_idx] <= stage_req.value;
      end
    end
  end

  `LKVC_ASSERT_NEXT(a_stage_gives_done, stage_valid, done, "accepted transaction gave no result")
  `LKVC_ASSERT_NEXT(a_evict_keeps_occ, stage_valid && evict, occupancy == $past(occupancy), "eviction changed occupancy")
  `LKVC_ASSERT_SAME(a_occ_tracks_valid, 1'b1, $countones(entry_valid) == occupancy, "occupancy differs from valid count")

endmodule

### dv/lru_key_value_cache_core_tb.sv
// Self-checking testbench for lru_key_value_cache_core: LRU cache accesses and capacity writes.
// Keeps its own model of the entries and ranks and checks every response in order.
// Depends on lkvc_pkg and lru_key_value_cache_core.
`timescale 1ns / 1ps

module lru_key_value_cache_core_tb;
  import lkvc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int RANDOM_ITEMS   = 600;
  localparam int POOL_SIZE      = 20;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  lkvc_req_t          req;
  logic               done;
  lkvc_rsp_t          rsp;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CAP_W-1:0]   cfg_data;

  lru_key_value_cache_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // cache model
  logic                     cache_valid [ENTRIES];
  logic signed [DATA_W-1:0] cache_key   [ENTRIES];
  logic signed [DATA_W-1:0] cache_value [ENTRIES];
  int                       cache_age   [ENTRIES];
  int                       cache_count;
  logic [CAP_W-1:0]         capacity_reg;

  lkvc_rsp_t                pending_rsp_q [$];
  lkvc_rsp_t                predicted_rsp;
  lkvc_rsp_t                oldest_rsp;
  logic signed [DATA_W-1:0] key_pool [POOL_SIZE];

  int access_count;
  int hit_count;
  int evict_count;
  int mismatch_count;
  int stall_cycles;
  int sender_idle_pct;
  int eff_capacity;
  logic [CAP_W-1:0] chosen_capacity;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic lkvc_rsp_t predict_access(input lkvc_req_t a);
    lkvc_rsp_t o;
    int        hit_slot;
    int        slot;
    int        best;
    int        limit;
    int        r;
    o = '0;
    hit_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_valid[i] && cache_key[i] == a.key) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      o.found = 1'b1;
      hit_count++;
      if (a.operation == OP_GET) o.read_value = cache_value[hit_slot];
      else cache_value[hit_slot] = a.value;
      r = cache_age[hit_slot];
      for (int i = 0; i < ENTRIES; i++) begin
        if (cache_valid[i] && cache_age[i] < r) cache_age[i]++;
      end
      cache_age[hit_slot] = 0;
    end else if (a.operation == OP_GET) begin
      o.read_value = MISS_VALUE;
    end else begin
      limit = int'(capacity_reg);
      if (limit == 0) limit = 1;
      if (limit > ENTRIES) limit = ENTRIES;
      if (cache_count >= limit) begin
        slot = -1;
        best = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (cache_valid[i] && (slot < 0 || cache_age[i] > best)) begin
            slot = i;
            best = cache_age[i];
          end
        end
        if (slot >= 0) begin
          o.evicted     = 1'b1;
          o.evicted_key = cache_key[slot];
          cache_valid[slot] = 1'b0;
          cache_count--;
          evict_count++;
        end
      end
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !cache_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (cache_valid[i]) cache_age[i]++;
        end
        cache_valid[slot] = 1'b1;
        cache_key[slot]   = a.key;
        cache_value[slot] = a.value;
        cache_age[slot]   = 0;
        cache_count++;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                                 input logic [DATA_W-1:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, exp_v, act_v);
    end
  endtask

  // predict on each accepted transaction, check each response
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        cache_valid[i] = 1'b0;
        cache_key[i]   = '0;
        cache_value[i] = '0;
        cache_age[i]   = 0;
      end
      cache_count  = 0;
      capacity_reg = CAP_RESET;
    end else begin
      if (cfg_valid && cfg_ready && cache_count == 0) capacity_reg = cfg_data;
      if (start && !busy) begin
        predicted_rsp = predict_access(req);
        pending_rsp_q = {pending_rsp_q, predicted_rsp};
        access_count++;
      end
      if (done) begin
        if (pending_rsp_q.size() == 0) begin
          report_mismatch("unexpected response", '0, rsp.read_value);
        end else begin
          oldest_rsp = pending_rsp_q.pop_front();
          if (rsp.found !== oldest_rsp.found)
            report_mismatch("found", DATA_W'(oldest_rsp.found), DATA_W'(rsp.found));
          if (rsp.read_value !== oldest_rsp.read_value)
            report_mismatch("read_value", oldest_rsp.read_value, rsp.read_value);
          if (rsp.evicted !== oldest_rsp.evicted)
            report_mismatch("evicted", DATA_W'(oldest_rsp.evicted), DATA_W'(rsp.evicted));
          if (rsp.evicted_key !== oldest_rsp.evicted_key)
            report_mismatch("evicted_key", oldest_rsp.evicted_key, rsp.evicted_key);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d cycles without a transaction", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_access(input logic op, input logic signed [DATA_W-1:0] k,
                             input logic signed [DATA_W-1:0] v);
    lkvc_req_t item;
    lkvc_req_t noise;
    while ($urandom_range(99) < sender_idle_pct) begin
      noise.operation = 1'($urandom_range(1));
      noise.key       = $urandom;
      noise.value     = $urandom;
      start <= 1'b0;
      req   <= noise;
      @(posedge clk);
    end
    item.operation = op;
    item.key       = k;
    item.value     = v;
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_responses();
    start <= 1'b0;
    while (pending_rsp_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_responses();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // only gets, so the cache stays empty and every write takes effect
  task automatic test_capacity_extremes();
    write_capacity(5'd0);
    send_access(OP_GET, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_access(OP_GET, 32'sh7FFF_FFFF, 32'sh8000_0000);
    write_capacity(5'd31);
    send_access(OP_GET, 32'sd0, 32'sd0);
    send_access(OP_GET, -32'sd1, -32'sd1);
    write_capacity(5'd17);
    send_access(OP_GET, 32'sd1, 32'sh7FFF_FFFF);
  endtask

  task automatic test_directed_access();
    chosen_capacity = CAP_W'($urandom_range(0, 31));
    eff_capacity = int'(chosen_capacity);
    if (eff_capacity == 0) eff_capacity = 1;
    if (eff_capacity > ENTRIES) eff_capacity = ENTRIES;
    write_capacity(chosen_capacity);
    send_access(OP_SET, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_access(OP_GET, 32'sh8000_0000, 32'sd0);
    send_access(OP_SET, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_access(OP_SET, -32'sd1, -32'sd1);
    send_access(OP_SET, 32'sh7FFF_FFFF, 32'sd0);
    send_access(OP_GET, 32'sh7FFF_FFFF, -32'sd1);
    send_access(OP_GET, 32'sd42, 32'sd0);
    for (int i = 0; i <= eff_capacity; i++) begin
      send_access(OP_SET, 32'sd100 + i, $urandom);
    end
    send_access(OP_GET, 32'sd100, 32'sd0);
    send_access(OP_GET, 32'sd100 + eff_capacity, 32'sd0);
  endtask

  // the cache is not empty here, so the write must be ignored
  task automatic test_ignored_capacity_write();
    write_capacity((eff_capacity == 1) ? 5'd16 : 5'd1);
    send_access(OP_SET, 32'sd500, $urandom);
    send_access(OP_SET, 32'sd501, $urandom);
    send_access(OP_GET, 32'sd500, 32'sd0);
  endtask

  task automatic test_random_access(input int idle_pct, input int n);
    int                       pick;
    int                       pool_n;
    logic signed [DATA_W-1:0] k;
    sender_idle_pct = idle_pct;
    pool_n = (eff_capacity + 4 < POOL_SIZE) ? eff_capacity + 4 : POOL_SIZE;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 80) k = key_pool[$urandom_range(0, pool_n - 1)];
      else if (pick < 85) k = ($urandom_range(1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      else k = $urandom;
      send_access(1'($urandom_range(1)), k, $urandom);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    access_count    = 0;
    hit_count       = 0;
    evict_count     = 0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_capacity_extremes();
    test_directed_access();
    test_ignored_capacity_write();
    test_random_access(18, RANDOM_ITEMS);
    test_random_access(84, RANDOM_ITEMS);
    test_random_access(0, RANDOM_ITEMS);
    drain_responses();

    $display("Covered %0d accesses with %0d hits and %0d evictions at capacity setting %0d.",
             access_count, hit_count, evict_count, chosen_capacity);
    $display("Capacity writes of 0, 31 and 17 on an empty cache and one while occupied.");
    if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatch_count, pending_rsp_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/lkvc_pkg.sv
sv/lkvc_lookup.sv
sv/lru_key_value_cache_core.sv
dv/lru_key_value_cache_core_tb.sv
